>>> hw/rtl/bdgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdgc_pkg;

	localparam int TIME_BITS      = 32;
	localparam int CMP_BITS       = (TIME_BITS > 20) ? TIME_BITS : 20;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 32;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CMP_BITS-1:0]  cmp_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DEBOUNCE_TIME   = 8'd0,
		REG_LONG_PRESS_TIME = 8'd1,
		REG_RESET_HOLD_TIME = 8'd2,
		REG_POLARITY_HIGH   = 8'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		GESTURE_TAP   = 2'd0,
		GESTURE_LONG  = 2'd1,
		GESTURE_RESET = 2'd2
	} gesture_t;

	typedef struct packed {
		logic [15:0] debounce_time;
		logic [19:0] long_press_time;
		logic [19:0] reset_hold_time;
		logic        polarity_high;
	} cfg_t;

	localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
	localparam logic [19:0] LONG_PRESS_RESET = 20'd1000;
	localparam logic [19:0] RESET_HOLD_RESET = 20'd10000;

endpackage

`default_nettype wire

>>> hw/rtl/bdgc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bdgc_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [bdgc_pkg::CFG_INDEX_BITS-1:0] wr_index,
	input  wire logic [bdgc_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output bdgc_pkg::cfg_t                           cfg
);

	bdgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= bdgc_pkg::DEBOUNCE_RESET;
			cfg_q.long_press_time <= bdgc_pkg::LONG_PRESS_RESET;
			cfg_q.reset_hold_time <= bdgc_pkg::RESET_HOLD_RESET;
			cfg_q.polarity_high   <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				bdgc_pkg::REG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= wr_data[15:0];
				bdgc_pkg::REG_LONG_PRESS_TIME: cfg_q.long_press_time <= wr_data[19:0];
				bdgc_pkg::REG_RESET_HOLD_TIME: cfg_q.reset_hold_time <= wr_data[19:0];
				bdgc_pkg::REG_POLARITY_HIGH:   cfg_q.polarity_high   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/bdgc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bdgc_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bdgc_pkg::cfg_t  cfg,
	input  wire logic            step,
	input  wire logic            pin,
	input  wire bdgc_pkg::time_t now,
	output logic                 res_valid,
	output bdgc_pkg::gesture_t   res_gesture
);

	logic            started_q;
	logic            raw_pressed_q;
	logic            stable_pressed_q;
	bdgc_pkg::time_t raw_change_time_q;
	bdgc_pkg::time_t press_start_time_q;
	logic            long_reported_q;
	logic            reset_reported_q;

	logic            cur;
	logic            raw_n;
	logic            stable_n;
	bdgc_pkg::time_t rct_n;
	bdgc_pkg::time_t pst_n;
	logic            lr_n;
	logic            rr_n;
	bdgc_pkg::time_t el_raw;
	bdgc_pkg::time_t el_press;
	logic            deb_fire;
	logic            tap;
	logic            reset_fire;
	logic            long_fire;

	always_comb begin
		cur      = cfg.polarity_high ? pin : !pin;
		raw_n    = cur;
		rct_n    = (cur != raw_pressed_q) ? now : raw_change_time_q;
		el_raw   = now - rct_n;
		deb_fire = (raw_n != stable_pressed_q) &&
			(bdgc_pkg::cmp_t'(el_raw) >= bdgc_pkg::cmp_t'(cfg.debounce_time));
		stable_n = deb_fire ? raw_n : stable_pressed_q;
		pst_n    = press_start_time_q;
		lr_n     = long_reported_q;
		rr_n     = reset_reported_q;
		if (deb_fire && raw_n) begin
			pst_n = now;
			lr_n  = 1'b0;
			rr_n  = 1'b0;
		end
		tap        = deb_fire && !raw_n && !long_reported_q;
		el_press   = now - pst_n;
		reset_fire = stable_n && (cfg.reset_hold_time != 20'd0) && !rr_n &&
			(bdgc_pkg::cmp_t'(el_press) >= bdgc_pkg::cmp_t'(cfg.reset_hold_time));
		long_fire  = stable_n && !lr_n && !reset_fire &&
			(bdgc_pkg::cmp_t'(el_press) >= bdgc_pkg::cmp_t'(cfg.long_press_time));
		if (reset_fire) begin
			rr_n = 1'b1;
			lr_n = 1'b1;
		end else if (long_fire) begin
			lr_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q          <= 1'b0;
			raw_pressed_q      <= 1'b0;
			stable_pressed_q   <= 1'b0;
			raw_change_time_q  <= '0;
			press_start_time_q <= '0;
			long_reported_q    <= 1'b0;
			reset_reported_q   <= 1'b0;
		end else if (step) begin
			if (!started_q) begin
				started_q        <= 1'b1;
				raw_pressed_q    <= cur;
				stable_pressed_q <= cur;
			end else begin
				raw_pressed_q      <= raw_n;
				stable_pressed_q   <= stable_n;
				raw_change_time_q  <= rct_n;
				press_start_time_q <= pst_n;
				long_reported_q    <= lr_n;
				reset_reported_q   <= rr_n;
			end
		end
	end

	always_comb begin
		res_valid   = started_q && (tap || reset_fire || long_fire);
		res_gesture = bdgc_pkg::GESTURE_TAP;
		if (reset_fire) begin
			res_gesture = bdgc_pkg::GESTURE_RESET;
		end else if (long_fire) begin
			res_gesture = bdgc_pkg::GESTURE_LONG;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && (res_gesture != bdgc_pkg::GESTURE_TAP) |=> long_reported_q)
		else $error("long press flag not set after hold gesture");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && (res_gesture == bdgc_pkg::GESTURE_TAP) |=> !stable_pressed_q)
		else $error("tap given without stable release");

	assert property (@(posedge clk) disable iff (!arst_n)
		reset_reported_q |-> long_reported_q)
		else $error("reset hold reported without long press flag");

endmodule

`default_nettype wire

>>> hw/rtl/button_debounce_gesture_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Button debounce and gesture classifier. Each item is one pin sample with a
// millisecond timestamp; the block debounces the level and reports a single
// tap, a long press or a factory reset hold, at most one gesture per item.
// One item is taken every clock while the output is not stalled. An item is
// registered on acceptance; its gesture (if any) is worked out against the
// debounce state and lands in the output register once the output can take
// it. The debounce state updates once per item. The user must make register
// writes only while the block is idle; the block itself does not enforce it.
module button_debounce_gesture_classifier_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                pin_level,
	input  wire logic [31:0]                         now_time,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [1:0]                               gesture,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bdgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bdgc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	bdgc_pkg::cfg_t     cfg;
	logic               valid_s1;
	logic               pin_s1;
	bdgc_pkg::time_t    now_s1;
	logic               out_valid_q;
	logic [1:0]         gesture_q;
	logic               adv;
	logic               res_valid;
	bdgc_pkg::gesture_t res_gesture;

	assign cfg_ready = 1'b1;

	bdgc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || adv) && in_valid) begin
			pin_s1 <= pin_level;
			now_s1 <= bdgc_pkg::time_t'(now_time);
		end
	end

	bdgc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (valid_s1 && adv),
		.pin         (pin_s1),
		.now         (now_s1),
		.res_valid   (res_valid),
		.res_gesture (res_gesture)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			gesture_q <= res_gesture;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held back while output free");

	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && !out_stall |=> !out_valid)
		else $error("result invented with no item in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture != 2'd3))
		else $error("gesture code out of range");

endmodule

`default_nettype wire
